>>> hw/rtl/primality_test_hybrid_assert.svh
// Assertion macros for the primality test block.
// Used by primality_test_hybrid.sv; no other dependencies.
`ifndef PRIMALITY_TEST_HYBRID_ASSERT_SVH
`define PRIMALITY_TEST_HYBRID_ASSERT_SVH

// Same-cycle implication.
`define PTH_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// Next-cycle implication.
`define PTH_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/pth_pkg.sv
// Shared types and constants for the primality test block.
// No dependencies.
`timescale 1ns / 1ps
package pth_pkg;
   localparam int NUM_WIDTH = 32;
   localparam logic [31:0] SMALL_LIMIT = 32'h0000_FFFF;

   typedef enum logic [1:0] {
      METHOD_TRIAL  = 2'd0,
      METHOD_MR     = 2'd1,
      METHOD_HYBRID = 2'd2,
      METHOD_ALT    = 2'd3
   } method_type;

   typedef struct packed {
      logic [31:0] candidate;
      logic [31:0] witness;
   } req_type;

   typedef struct packed {
      logic is_prime;
      logic used_trial_division;
   } rsp_type;
endpackage

>>> hw/rtl/primality_test_hybrid.sv
// Primality test block: trial division and one Miller-Rabin round on a shared
// multiplier and bit-serial modular reducer. Depends on pth_pkg and the assert header.
//
// Usage:
//   Input: pulse start with req_data while busy is low; the item is taken then and
//   busy stays high until the result is out.
//   Result: rsp_valid is high for one cycle with rsp_data; the receiver cannot stall.
//   Config: csr_valid/csr_ready write test_method (csr_ready is always high); write
//   only while busy is low.
//   Work: small and even candidates are decided without a reduction. Trial division
//   does one square, compare and modular reduction per odd divisor up to the square
//   root. A Miller-Rabin round does at most about 2*NUM_WIDTH modular multiplies.
//   The single reducer produces one quotient bit per cycle.
//   Throughput: one item at a time; the next is taken at the edge that takes the result.
//   Reset: synchronous; clears the sequencer and sets test_method to trial division.
`timescale 1ns / 1ps
`include "primality_test_hybrid_assert.svh"
module primality_test_hybrid
   import pth_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data
);
   localparam int W  = NUM_WIDTH;
   localparam int CW = $clog2(2 * W + 1);
   localparam int SW = $clog2(W + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_DECIDE, S_TD_SQ, S_TD_CMP, S_TD_REM, S_MR_SHIFT, S_MR_BASE,
      S_MP_TOP, S_MP_RSET, S_MP_BMUL, S_MP_BSET, S_MR_CHECK, S_MR_LOOP,
      S_MR_SQSET, S_MODLOAD, S_MOD
   } state_type;

   state_type        state_ff, state_in, ret_ff, ret_in;
   method_type       method_ff, method_in;
   logic [W-1:0]     n_ff, n_in, dv_ff, dv_in, r_ff, r_in, b_ff, b_in;
   logic [W-1:0]     rem_ff, rem_in;
   logic [2*W-1:0]   prod_ff, prod_in, dvd_ff, dvd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [SW-1:0]    s_ff, s_in;
   logic             trial_ff, trial_in, rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [W-1:0]     div;
   logic [W:0]       t;
   logic             ge;
   logic [W-1:0]     n_m1, mul_a, mul_b;
   logic             in_trial;
   logic [W-1:0]     cand;

   assign div  = trial_ff ? dv_ff : n_ff;
   assign t    = {rem_ff, dvd_ff[2*W-1]};
   assign ge   = t >= {1'b0, div};
   assign n_m1 = n_ff - W'(1);
   assign cand = req_data.candidate[W-1:0];

   always_comb begin
      in_trial = (method_ff == METHOD_TRIAL) || (cand == '1) ||
                 ((method_ff != METHOD_MR) && (32'(cand) < SMALL_LIMIT));
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      method_in    = method_ff;
      n_in         = n_ff;
      dv_in        = dv_ff;
      r_in         = r_ff;
      b_in         = b_ff;
      rem_in       = rem_ff;
      prod_in      = prod_ff;
      dvd_in       = dvd_ff;
      cnt_in       = cnt_ff;
      s_in         = s_ff;
      trial_in     = trial_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mul_a        = b_ff;
      mul_b        = b_ff;
      if (csr_valid) begin
         method_in = method_type'(csr_data);
      end
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               n_in     = cand;
               b_in     = req_data.witness[W-1:0];
               trial_in = in_trial;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            rsp_in.used_trial_division = trial_ff;
            if (trial_ff) begin
               if (n_ff == W'(2) || n_ff == W'(3) || n_ff == W'(5) || n_ff == W'(7)) begin
                  rsp_in.is_prime = 1'b1;
                  rsp_valid_in    = 1'b1;
                  state_in        = S_IDLE;
               end else if (!n_ff[0] || n_ff < W'(11)) begin
                  rsp_in.is_prime = 1'b0;
                  rsp_valid_in    = 1'b1;
                  state_in        = S_IDLE;
               end else begin
                  dv_in    = W'(3);
                  state_in = S_TD_SQ;
               end
            end else begin
               if (n_ff == W'(2) || n_ff == W'(3)) begin
                  rsp_in.is_prime = 1'b1;
                  rsp_valid_in    = 1'b1;
                  state_in        = S_IDLE;
               end else if (!n_ff[0] || n_ff < W'(4)) begin
                  rsp_in.is_prime = 1'b0;
                  rsp_valid_in    = 1'b1;
                  state_in        = S_IDLE;
               end else begin
                  dv_in    = n_m1;
                  s_in     = '0;
                  state_in = S_MR_SHIFT;
               end
            end
         end
         S_TD_SQ: begin
            mul_a    = dv_ff;
            mul_b    = dv_ff;
            prod_in  = mul_a * mul_b;
            state_in = S_TD_CMP;
         end
         S_TD_CMP: begin
            if (prod_ff > {{W{1'b0}}, n_ff}) begin
               rsp_in.is_prime = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end else begin
               dvd_in   = {n_ff, {W{1'b0}}};
               cnt_in   = CW'(W);
               rem_in   = '0;
               ret_in   = S_TD_REM;
               state_in = S_MOD;
            end
         end
         S_TD_REM: begin
            if (rem_ff == '0) begin
               rsp_in.is_prime = 1'b0;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end else begin
               dv_in    = dv_ff + W'(2);
               state_in = S_TD_SQ;
            end
         end
         S_MR_SHIFT: begin
            if (!dv_ff[0]) begin
               dv_in = dv_ff >> 1;
               s_in  = s_ff + SW'(1);
            end else begin
               dvd_in   = {b_ff, {W{1'b0}}};
               cnt_in   = CW'(W);
               rem_in   = '0;
               ret_in   = S_MR_BASE;
               state_in = S_MOD;
            end
         end
         S_MR_BASE: begin
            b_in     = rem_ff;
            r_in     = W'(1);
            state_in = S_MP_TOP;
         end
         S_MP_TOP: begin
            if (dv_ff == '0) begin
               b_in     = r_ff;
               state_in = S_MR_CHECK;
            end else if (dv_ff[0]) begin
               mul_a    = r_ff;
               prod_in  = mul_a * mul_b;
               ret_in   = S_MP_RSET;
               state_in = S_MODLOAD;
            end else begin
               state_in = S_MP_BMUL;
            end
         end
         S_MP_RSET: begin
            r_in     = rem_ff;
            state_in = S_MP_BMUL;
         end
         S_MP_BMUL: begin
            prod_in  = mul_a * mul_b;
            ret_in   = S_MP_BSET;
            state_in = S_MODLOAD;
         end
         S_MP_BSET: begin
            b_in     = rem_ff;
            dv_in    = dv_ff >> 1;
            state_in = S_MP_TOP;
         end
         S_MR_CHECK: begin
            if (b_ff == W'(1) || b_ff == n_m1) begin
               rsp_in.is_prime = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end else begin
               state_in = S_MR_LOOP;
            end
         end
         S_MR_LOOP: begin
            if (s_ff == '0) begin
               rsp_in.is_prime = 1'b0;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end else begin
               prod_in  = mul_a * mul_b;
               s_in     = s_ff - SW'(1);
               ret_in   = S_MR_SQSET;
               state_in = S_MODLOAD;
            end
         end
         S_MR_SQSET: begin
            b_in = rem_ff;
            if (rem_ff == W'(1)) begin
               rsp_in.is_prime = 1'b0;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end else if (rem_ff == n_m1) begin
               rsp_in.is_prime = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end else begin
               state_in = S_MR_LOOP;
            end
         end
         S_MODLOAD: begin
            dvd_in   = prod_ff;
            cnt_in   = CW'(2 * W);
            rem_in   = '0;
            state_in = S_MOD;
         end
         S_MOD: begin
            rem_in = ge ? W'(t - {1'b0, div}) : t[W-1:0];
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         method_ff    <= METHOD_TRIAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         method_ff    <= method_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff     <= n_in;
      dv_ff    <= dv_in;
      r_ff     <= r_in;
      b_ff     <= b_in;
      rem_ff   <= rem_in;
      prod_ff  <= prod_in;
      dvd_ff   <= dvd_in;
      cnt_ff   <= cnt_in;
      s_ff     <= s_in;
      trial_ff <= trial_in;
      rsp_ff   <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   `PTH_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `PTH_ASSERT_NOW(a_rsp_after_work, clock, reset, rsp_valid, !busy && $past(busy))
   `PTH_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
endmodule

>>> tb/sv/primality_test_hybrid_checker.sv
// Result checker for the primality test block: predicts each item from its request
// and the last written method, then compares each result. Depends on pth_pkg.
`timescale 1ns / 1ps
module primality_test_hybrid_checker
   import pth_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  rsp_type    rsp_data,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [1:0] csr_data,
   output int         errors,
   output int         pending
);
   localparam logic [63:0] ALL_ONES = (64'd1 << NUM_WIDTH) - 64'd1;

   method_type method_q;
   rsp_type    verdicts_q[$];

   function automatic logic [63:0] pow_mod(logic [63:0] b, logic [63:0] e, logic [63:0] n);
      logic [63:0] r;
      r = 64'd1;
      b = b % n;
      while (e != 0) begin
         if (e[0]) r = (r * b) % n;
         e = e >> 1;
         b = (b * b) % n;
      end
      return r;
   endfunction

   function automatic logic divides_out(logic [63:0] n);
      logic [63:0] d;
      if (n == 2 || n == 3 || n == 5 || n == 7) return 1'b1;
      if (!n[0] || n < 11) return 1'b0;
      for (d = 3; d <= n / d; d += 2)
         if (n % d == 0) return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic mr_passes(logic [63:0] n, logic [63:0] w);
      logic [63:0] d;
      logic [63:0] x;
      if (n == 2 || n == 3) return 1'b1;
      if (!n[0] || n < 4) return 1'b0;
      d = n - 1;
      while (!d[0]) d = d >> 1;
      x = pow_mod(w, d, n);
      if (x == 1 || x == n - 1) return 1'b1;
      while (d != n - 1) begin
         x = (x * x) % n;
         d = d << 1;
         if (x == 1) return 1'b0;
         if (x == n - 1) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic rsp_type predict_verdict(req_type req, method_type m);
      rsp_type     r;
      logic [63:0] n;
      logic [63:0] w;
      n = {32'd0, req.candidate} & ALL_ONES;
      w = {32'd0, req.witness} & ALL_ONES;
      if (m == METHOD_TRIAL || n == ALL_ONES) r.used_trial_division = 1'b1;
      else if (m == METHOD_MR) r.used_trial_division = 1'b0;
      else r.used_trial_division = (n < {32'd0, SMALL_LIMIT});
      r.is_prime = r.used_trial_division ? divides_out(n) : mr_passes(n, w);
      return r;
   endfunction

   assign pending = verdicts_q.size();

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         method_q <= METHOD_TRIAL;
         verdicts_q.delete();
         errors <= 0;
      end else begin
         if (csr_valid && csr_ready) method_q <= method_type'(csr_data);
         if (start && !busy) verdicts_q.push_back(predict_verdict(req_data, method_q));
         if (rsp_valid) begin
            if (verdicts_q.size() == 0) begin
               errors <= errors + 1;
               if (errors < 10) $display("unexpected result %b", rsp_data);
            end else begin
               exp_r = verdicts_q.pop_front();
               if (exp_r !== rsp_data) begin
                  errors <= errors + 1;
                  if (errors < 10)
                     $display("mismatch: is_prime exp %b got %b, trial exp %b got %b",
                              exp_r.is_prime, rsp_data.is_prime,
                              exp_r.used_trial_division, rsp_data.used_trial_division);
               end
            end
         end
      end
   end
endmodule

>>> tb/sv/tb_primality_test_hybrid.sv
// Testbench top for the primality test block: drives directed and random items over
// all methods, and gives the verdict. Depends on pth_pkg, the block and the checker.
`timescale 1ns / 1ps
module tb_primality_test_hybrid;
   import pth_pkg::*;

   localparam int STALL_LIMIT = 400000;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_data;
   int         errors;
   int         pending;
   int         quiet_cycles;
   logic       steady;
   logic [31:0] trial_cands [0:10];

   primality_test_hybrid u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   primality_test_hybrid_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data), .errors(errors), .pending(pending)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic send_item(logic [31:0] cand, logic [31:0] wit);
      start <= 1'b1;
      req_data <= '{candidate: cand, witness: wit};
      do @(posedge clock); while (busy);
      if (!steady && $urandom_range(0, 99) < 16) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic set_method(method_type m);
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_candidate(method_type m);
      if (m == METHOD_TRIAL || $urandom_range(0, 1) == 0)
         return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1 << 18)
                                            : $urandom_range(0, 32'hFFFF);
      return $urandom() | ($urandom_range(0, 3) != 0);
   endfunction

   task automatic random_items(method_type m, int count);
      logic [31:0] c;
      logic [31:0] w;
      for (int i = 0; i < count; i++) begin
         c = pick_candidate(m);
         w = ($urandom_range(0, 1) == 0 || c < 4) ? $urandom()
                                                   : $urandom_range(2, c - 2);
         send_item(c, w);
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = METHOD_TRIAL;
      steady = 1'b0;
      quiet_cycles = 0;
      trial_cands = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd7, 32'd9, 32'd11, 32'd25,
                      32'd65521, 32'hFFFF_FFFF};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      set_method(METHOD_TRIAL);
      foreach (trial_cands[i])
         send_item(trial_cands[i], $urandom());
      set_method(METHOD_MR);
      send_item(32'd2, 32'd0);
      send_item(32'd3, 32'd1);
      send_item(32'd1, 32'd2);
      send_item(32'd4294967291, 32'd0);
      send_item(32'd4294967291, 32'd1);
      send_item(32'd4294967291, 32'd4294967290);
      send_item(32'd4294967291, 32'hFFFF_FFFF);
      send_item(32'd561, 32'd2);
      send_item(32'hFFFF_FFFF, 32'd2);
      set_method(METHOD_HYBRID);
      send_item(32'hFFFE, 32'd3);
      send_item(32'hFFFF, 32'd2);
      send_item(32'd65537, 32'd3);
      set_method(METHOD_ALT);
      send_item(32'd5, 32'd2);

      random_items(METHOD_ALT, 10);
      set_method(METHOD_HYBRID);
      steady = 1'b1;
      random_items(METHOD_HYBRID, 30);
      steady = 1'b0;
      set_method(METHOD_TRIAL);
      random_items(METHOD_TRIAL, 25);
      set_method(METHOD_MR);
      random_items(METHOD_MR, 25);
      set_method(METHOD_HYBRID);
      random_items(METHOD_HYBRID, 10);
      start <= 1'b0;

      @(posedge clock);
      while (pending != 0 || busy) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
